// ===== src/dis_pkg.sv =====
// Shared types and constants for the dual interleaved stack.
`timescale 1ns / 1ps

package dis_pkg;

   // Entries per stack and derived widths.
   localparam int DEPTH       = 1024;
   localparam int STORE_WORDS = 2 * DEPTH;
   localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int HEIGHT_W    = 11;
   localparam int CMD_W       = 2;

   // Command codes; code 3 is not a command and leaves both stacks as they are.
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TOP  = 2'd2;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic exec;
      logic load_read;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic read_needed;
   } dp_status_type;

   // Stack height as reported on the result port.
   function automatic logic [HEIGHT_W-1:0] to_height(input logic [CNT_W-1:0] cnt);
      return HEIGHT_W'(cnt);
   endfunction

endpackage

// ===== src/dis_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module dis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dis_ctrl.sv =====
// Controller state machine that sequences one beat through the datapath.
`timescale 1ns / 1ps

module dis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dis_pkg::dp_cmd_type    dp_cmd,
   input  dis_pkg::dp_status_type dp_status
);
   import dis_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = dp_status.read_needed ? S_LOAD : S_RESP;
         end
         S_LOAD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready        = 1'b1;
            dp_cmd.load_item = req_valid;
         end
         S_EXEC: begin
            dp_cmd.exec = 1'b1;
         end
         S_LOAD: begin
            dp_cmd.load_read = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/dis_dp.sv =====
// Datapath: item latch, stack heights, shared word store and result register.
`timescale 1ns / 1ps

module dis_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dis_pkg::dp_cmd_type                  dp_cmd,
   output dis_pkg::dp_status_type               dp_status,
   input  logic [dis_pkg::CMD_W-1:0]            req_cmd,
   input  logic                                 req_stack_sel,
   input  logic signed [dis_pkg::DATA_W-1:0]    req_push_value,
   output logic signed [dis_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [1:0]                           rsp_status,
   output logic [dis_pkg::HEIGHT_W-1:0]         rsp_even_height,
   output logic [dis_pkg::HEIGHT_W-1:0]         rsp_odd_height
);
   import dis_pkg::*;

   logic [CMD_W-1:0]  cmd_ff;
   logic              sel_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]  even_cnt_ff;
   logic [CNT_W-1:0]  even_cnt_in;
   logic [CNT_W-1:0]  odd_cnt_ff;
   logic [CNT_W-1:0]  odd_cnt_in;
   logic [DATA_W-1:0] read_value_ff;
   status_type        status_ff;
   status_type        status_in;

   logic [CNT_W-1:0]  cnt;
   logic [CNT_W-1:0]  cnt_next;
   logic              is_push;
   logic              is_read;
   logic              full;
   logic              empty;
   logic              push_ok;
   logic              read_ok;
   logic [PTR_W-1:0]  pos;
   logic [ADDR_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // Latch the item when it is accepted.
   always_ff @(posedge clock) begin
      if (dp_cmd.load_item) begin
         cmd_ff   <= req_cmd;
         sel_ff   <= req_stack_sel;
         value_ff <= req_push_value;
      end
   end

   // Decode the command against the selected stack's height.
   always_comb begin
      cnt     = sel_ff ? odd_cnt_ff : even_cnt_ff;
      is_push = (cmd_ff == CMD_PUSH);
      is_read = (cmd_ff == CMD_POP) || (cmd_ff == CMD_TOP);
      full    = (cnt >= CNT_W'(DEPTH));
      empty   = (cnt == '0);
      push_ok = is_push && !full;
      read_ok = is_read && !empty;
      pos     = is_push ? PTR_W'(cnt) : PTR_W'(cnt - CNT_W'(1));
   end

   // Stack k's entry at position p lives in word 2*p + k.
   assign ram_addr = ADDR_W'({pos, sel_ff});

   // New height and status of the selected stack.
   always_comb begin
      cnt_next  = cnt;
      status_in = ST_OK;
      priority if (push_ok) begin
         cnt_next = cnt + CNT_W'(1);
      end else if (read_ok && (cmd_ff == CMD_POP)) begin
         cnt_next = cnt - CNT_W'(1);
      end else begin
         cnt_next = cnt;
      end
      priority if (is_push && full) begin
         status_in = ST_OVER;
      end else if (is_read && empty) begin
         status_in = ST_UNDER;
      end else begin
         status_in = ST_OK;
      end
      even_cnt_in = even_cnt_ff;
      odd_cnt_in  = odd_cnt_ff;
      if (dp_cmd.exec) begin
         if (sel_ff) begin
            odd_cnt_in = cnt_next;
         end else begin
            even_cnt_in = cnt_next;
         end
      end
   end

   // Height registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         even_cnt_ff <= '0;
         odd_cnt_ff  <= '0;
      end else begin
         even_cnt_ff <= even_cnt_in;
         odd_cnt_ff  <= odd_cnt_in;
      end
   end

   // Shared word store for both stacks.
   dis_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STORE_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.exec && push_ok),
      .rd_en   (dp_cmd.exec && read_ok),
      .addr    (ram_addr),
      .wr_data (value_ff),
      .rd_data (ram_rd_data)
   );

   // Result register: status on execute, read word once the store answers.
   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         status_ff     <= status_in;
         read_value_ff <= '0;
      end else if (dp_cmd.load_read) begin
         read_value_ff <= ram_rd_data;
      end
   end

   assign dp_status.read_needed = read_ok;

   assign rsp_read_value  = read_value_ff;
   assign rsp_status      = status_ff;
   assign rsp_even_height = to_height(even_cnt_ff);
   assign rsp_odd_height  = to_height(odd_cnt_ff);

endmodule

// ===== src/dual_interleaved_stack_core.sv =====
// Top level of the dual interleaved stack: controller plus datapath.
`timescale 1ns / 1ps
// A push, an error or an unused-code beat goes through the execute state to the result state;
// a pop or top also passes the load state, for the registered read of the word store.
// No new beat is taken until the result is taken, so one item is in flight,
// paced by the controller.
// Reset clears both stack heights and the controller; store contents are left as is.

module dual_interleaved_stack_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dis_pkg::CMD_W-1:0]         req_cmd,
   input  logic                              req_stack_sel,
   input  logic signed [dis_pkg::DATA_W-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [dis_pkg::DATA_W-1:0] rsp_read_value,
   output logic [1:0]                        rsp_status,
   output logic [dis_pkg::HEIGHT_W-1:0]      rsp_even_height,
   output logic [dis_pkg::HEIGHT_W-1:0]      rsp_odd_height
);
   import dis_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencing.
   dis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // Heights, store and result.
   dis_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .req_cmd         (req_cmd),
      .req_stack_sel   (req_stack_sel),
      .req_push_value  (req_push_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_even_height (rsp_even_height),
      .rsp_odd_height  (rsp_odd_height)
   );

endmodule

// ===== src/dis_checker.sv =====
// Port-level checks for the dual interleaved stack, bound to the top level.
`timescale 1ns / 1ps

module dis_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dis_pkg::DATA_W-1:0] rsp_read_value,
   input logic [1:0]                        rsp_status,
   input logic [dis_pkg::HEIGHT_W-1:0]      rsp_even_height,
   input logic [dis_pkg::HEIGHT_W-1:0]      rsp_odd_height
);
   import dis_pkg::*;

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_even_height) && $stable(rsp_odd_height))
      else $error("result beat changed while stalled");

   // Only one item is in flight: no new beat is taken while a result is shown.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a result is pending");

   // Accepting a beat closes the request side on the next cycle.
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after acceptance");

   // An error result carries a zero word.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNDER || rsp_status == ST_OVER)
         |-> rsp_read_value == '0)
      else $error("nonzero word on an error result");

   // The status field never shows the unused code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_UNDER
         || rsp_status == ST_OVER)
      else $error("unused status code on a result");

endmodule

bind dual_interleaved_stack_core dis_checker u_dis_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_value  (rsp_read_value),
   .rsp_status      (rsp_status),
   .rsp_even_height (rsp_even_height),
   .rsp_odd_height  (rsp_odd_height)
);

// ===== tb/stack_result_checker.sv =====
// Watches the dual stack's request and result beats, predicts each result and compares it.
`timescale 1ns / 1ps

module stack_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [dis_pkg::CMD_W-1:0]         req_cmd,
   input  logic                              req_stack_sel,
   input  logic signed [dis_pkg::DATA_W-1:0] req_push_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [dis_pkg::DATA_W-1:0] rsp_read_value,
   input  logic [1:0]                        rsp_status,
   input  logic [dis_pkg::HEIGHT_W-1:0]      rsp_even_height,
   input  logic [dis_pkg::HEIGHT_W-1:0]      rsp_odd_height,
   output int                                mismatch_count,
   output int                                pending_count
);
   import dis_pkg::*;

   // One predicted result beat.
   typedef struct packed {
      logic [DATA_W-1:0]   read_value;
      status_type          status;
      logic [HEIGHT_W-1:0] even_height;
      logic [HEIGHT_W-1:0] odd_height;
   } stack_result_type;

   // Shadow copy of the word store and both stack heights.
   logic [DATA_W-1:0] word_store [STORE_WORDS];
   logic [CNT_W-1:0]  stack_height [2];

   stack_result_type results_due [$];
   int errors = 0;
   int result_index = 0;

   assign mismatch_count = errors;
   assign pending_count  = results_due.size();

   // Prints one line per mismatch and counts it.
   task automatic flag_error(input string msg);
      $display("[%0t] result %0d: %s", $realtime, result_index, msg);
      errors++;
   endtask

   // Applies one command to the shadow stacks and returns the result it yields.
   function automatic stack_result_type apply_stack_command(input logic [CMD_W-1:0] cmd,
                                                            input logic sel,
                                                            input logic [DATA_W-1:0] word);
      stack_result_type res;
      logic [CNT_W-1:0] h;
      res.read_value = '0;
      res.status     = ST_OK;
      h = stack_height[sel];
      case (cmd)
         CMD_PUSH: begin
            if (int'(h) >= DEPTH) begin
               res.status = ST_OVER;
            end else begin
               // Stack 0 lives in even words, stack 1 in odd words.
               word_store[2 * int'(h) + int'(sel)] = word;
               stack_height[sel] = h + CNT_W'(1);
            end
         end
         CMD_POP, CMD_TOP: begin
            if (h == '0) begin
               res.status = ST_UNDER;
            end else begin
               res.read_value = word_store[2 * (int'(h) - 1) + int'(sel)];
               if (cmd == CMD_POP) begin
                  stack_height[sel] = h - CNT_W'(1);
               end
            end
         end
         default: ;
      endcase
      res.even_height = HEIGHT_W'(stack_height[0]);
      res.odd_height  = HEIGHT_W'(stack_height[1]);
      return res;
   endfunction

   // Predict on each accepted request beat, compare on each accepted result beat.
   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         stack_height[0] = '0;
         stack_height[1] = '0;
         results_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            results_due.push_back(apply_stack_command(req_cmd, req_stack_sel, req_push_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               flag_error($sformatf("unexpected result beat, read_value %h status %0d",
                                    rsp_read_value, rsp_status));
            end else begin
               want = results_due.pop_front();
               if (rsp_read_value !== want.read_value)
                  flag_error($sformatf("read_value %h, expected %h",
                                       rsp_read_value, want.read_value));
               if (rsp_status !== want.status)
                  flag_error($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_even_height !== want.even_height)
                  flag_error($sformatf("even_height %0d, expected %0d",
                                       rsp_even_height, want.even_height));
               if (rsp_odd_height !== want.odd_height)
                  flag_error($sformatf("odd_height %0d, expected %0d",
                                       rsp_odd_height, want.odd_height));
            end
            result_index++;
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the dual interleaved stack, with the result checker beside it.
`timescale 1ns / 1ps

module testbench;
   import dis_pkg::*;

   // The unused command code; the block answers it without touching either stack.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = CMD_PUSH;
   logic                     req_stack_sel = 1'b0;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [1:0]               rsp_status;
   logic [HEIGHT_W-1:0]      rsp_even_height;
   logic [HEIGHT_W-1:0]      rsp_odd_height;

   int mismatch_count;
   int pending_count;

   // Idle odds in percent, changed from phase to phase.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Stack heights as the stimulus sees them, used only to steer the random items.
   int fill_level [2] = '{0, 0};

   dual_interleaved_stack_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_stack_sel   (req_stack_sel),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_even_height (rsp_even_height),
      .rsp_odd_height  (rsp_odd_height)
   );

   stack_result_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_stack_sel   (req_stack_sel),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_even_height (rsp_even_height),
      .rsp_odd_height  (rsp_odd_height),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The result side stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offers one request beat and returns at the edge that accepts it. Valid is
   // only lowered when an idle cycle is taken, so back-to-back beats keep it high.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic sel,
                            input logic [DATA_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_stack_sel  <= sel;
      req_push_value <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (cmd)
         CMD_PUSH: if (fill_level[sel] < DEPTH) fill_level[sel]++;
         CMD_POP:  if (fill_level[sel] > 0) fill_level[sel]--;
         default: ;
      endcase
   endtask

   // One random command on the given stack, weighted by the push and pop odds.
   task automatic send_random_item(input int push_pct, input int pop_pct, input logic sel);
      int pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < push_pct)
         cmd = CMD_PUSH;
      else if (pick < push_pct + pop_pct)
         cmd = CMD_POP;
      else if (pick < 97)
         cmd = CMD_TOP;
      else
         cmd = CMD_UNUSED;
      send_item(cmd, sel, $urandom());
   endtask

   // Mostly pushes onto one stack, with random commands on the other stack between them.
   task automatic grow_stack(input logic sel, input int count);
      repeat (count) begin
         if (fill_level[sel] < DEPTH && $urandom_range(99) < 94)
            send_item(CMD_PUSH, sel, $urandom());
         else
            send_random_item(45, 30, ~sel);
      end
   endtask

   // Pushes one stack until it is full, with noise on both stacks, then overflows it.
   task automatic fill_stack(input logic sel);
      while (fill_level[sel] < DEPTH) begin
         if ($urandom_range(99) < 94)
            send_item(CMD_PUSH, sel, $urandom());
         else
            send_random_item(45, 30, 1'($urandom_range(1)));
      end
      repeat (3) send_item(CMD_PUSH, sel, $urandom());
      send_item(CMD_TOP, sel, $urandom());
   endtask

   // Main stimulus, phase by phase.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty stacks, extreme words, every command on both stacks.
      send_item(CMD_POP, 1'b0, 32'h5a5a_a5a5);
      send_item(CMD_TOP, 1'b1, 32'hffff_ffff);
      send_item(CMD_POP, 1'b1, 32'h0000_0001);
      send_item(CMD_PUSH, 1'b0, 32'h7fff_ffff);
      send_item(CMD_PUSH, 1'b1, 32'h8000_0000);
      send_item(CMD_TOP, 1'b0, $urandom());
      send_item(CMD_TOP, 1'b1, $urandom());
      send_item(CMD_PUSH, 1'b0, 32'h0000_0000);
      send_item(CMD_PUSH, 1'b1, 32'hffff_ffff);
      send_item(CMD_UNUSED, 1'b0, 32'hdead_beef);
      send_item(CMD_UNUSED, 1'b1, 32'hffff_ffff);
      send_item(CMD_POP, 1'b0, $urandom());
      send_item(CMD_TOP, 1'b0, $urandom());
      send_item(CMD_POP, 1'b0, $urandom());
      send_item(CMD_POP, 1'b0, $urandom());
      send_item(CMD_POP, 1'b1, $urandom());
      send_item(CMD_TOP, 1'b1, $urandom());
      send_item(CMD_POP, 1'b1, $urandom());
      send_item(CMD_POP, 1'b1, $urandom());
      send_item(CMD_TOP, 1'b1, $urandom());

      // No idling: grow stack 0 with random traffic on stack 1 mixed in.
      grow_stack(1'b0, 240);

      // Sender idles: keep growing stack 0.
      send_idle_pct = 67;
      grow_stack(1'b0, 240);

      // Receiver stalls: keep growing stack 0.
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      grow_stack(1'b0, 240);

      // Both sides idle now and then: fill stack 0 to its limit and past it,
      // then pop-heavy traffic on both stacks.
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      fill_stack(1'b0);
      repeat (40) send_random_item(20, 60, 1'($urandom_range(1)));
      send_item(CMD_POP, 1'b0, $urandom());
      send_item(CMD_TOP, 1'b1, $urandom());
      req_valid <= 1'b0;

      // Wait for every predicted result, then a few cycles for stray beats.
      recv_stall_pct = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hang guard.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
